// ===== src/kse_pkg.sv =====
// shared types and constants for the k-mer entropy block
`default_nettype none
package kse_pkg;

   localparam int SYMBOL_W   = 8;
   localparam int MODE_W     = 2;
   localparam int ORDER_W    = 3;
   localparam int G_W        = ORDER_W + 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 3;
   localparam int RES_W      = 20;
   localparam int OUT_SHIFT  = 16;
   localparam int FRAC_W     = 32;
   localparam int P_W        = FRAC_W + 1;
   localparam int STATUS_W   = 2;

   localparam logic [MODE_W-1:0] MODE_PLAIN     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_JOINT     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_COND      = 2'd2;
   localparam logic [MODE_W-1:0] MODE_JOINT_ALT = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORDER = 2'd1;

   localparam logic [MODE_W-1:0]  MODE_RESET  = MODE_JOINT;
   localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd0;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK, STATUS_ORDER_LARGE, STATUS_ORDER_LOW, STATUS_OVERFLOW
   } kse_status_type;

   typedef struct packed {
      logic bump;
      logic find;
      logic clear;
   } kse_tbl_cmd_type;

   typedef struct packed {
      logic busy;
      logic full;
   } kse_tbl_sts_type;

   typedef enum logic {TBL_IDLE, TBL_SCAN} kse_tbl_state_type;
   typedef enum logic [1:0] {LOG_IDLE, LOG_NORM, LOG_SQR} kse_log_state_type;
   typedef enum logic {DIV_IDLE, DIV_RUN} kse_div_state_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_GBUMP, ST_GWAIT, ST_PBUMP, ST_PWAIT, ST_FIN, ST_SUM,
      ST_LT_GO, ST_LT_WAIT, ST_RD, ST_GO, ST_WAIT, ST_PF_GO, ST_PF_WAIT,
      ST_LP_GO, ST_LP_WAIT, ST_MUL, ST_ACC, ST_MAX_GO, ST_MAX_WAIT, ST_EMIT
   } kse_state_type;

endpackage
`default_nettype wire

// ===== src/kse_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
`default_nettype none
module kse_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

// ===== src/kse_table.sv =====
// associative count table: linear search over the filled entries, bump, find or clear
`default_nettype none
module kse_table #(
   parameter int KEY_W   = 40,
   parameter int COUNT_W = 32,
   parameter int DEPTH   = 1024
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire kse_pkg::kse_tbl_cmd_type       cmd,
   input  wire logic [KEY_W-1:0]               key,
   input  wire logic                           scan_en,
   input  wire logic [$clog2(DEPTH)-1:0]       scan_addr,
   output kse_pkg::kse_tbl_sts_type            sts,
   output logic      [COUNT_W-1:0]             found_count,
   output logic      [KEY_W-1:0]               scan_key,
   output logic      [COUNT_W-1:0]             scan_count,
   output logic      [$clog2(DEPTH):0]         used
);
   import kse_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int UW = AW + 1;

   kse_tbl_state_type    state_ff, state_in;
   logic                 bump_ff, bump_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [UW-1:0]        idx_ff, idx_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic [AW-1:0]        chk_idx_ff, chk_idx_in;
   logic [UW-1:0]        used_ff, used_in;
   logic                 full_ff, full_in;
   logic [COUNT_W-1:0]   count_ff, count_in;

   logic                 rd_en, wr_en;
   logic [AW-1:0]        rd_addr, wr_addr;
   logic [KEY_W+COUNT_W-1:0] wr_data, rd_data;
   logic [KEY_W-1:0]     rd_key;
   logic [COUNT_W-1:0]   rd_count, rd_count_inc;
   logic                 hit, miss;

   kse_ram #(.WIDTH(KEY_W + COUNT_W), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_key       = rd_data[KEY_W+COUNT_W-1:COUNT_W];
   assign rd_count     = rd_data[COUNT_W-1:0];
   // saturating increment
   assign rd_count_inc = (rd_count == '1) ? rd_count : rd_count + COUNT_W'(1);
   assign hit  = (state_ff == TBL_SCAN) && chk_vld_ff && (rd_key == key_ff);
   assign miss = (state_ff == TBL_SCAN) && !chk_vld_ff && (idx_ff >= used_ff);

   always_comb begin
      state_in   = state_ff;
      bump_in    = bump_ff;
      key_in     = key_ff;
      idx_in     = idx_ff;
      chk_vld_in = 1'b0;
      chk_idx_in = chk_idx_ff;
      used_in    = used_ff;
      full_in    = full_ff;
      count_in   = count_ff;
      rd_en      = 1'b0;
      rd_addr    = scan_addr;
      wr_en      = 1'b0;
      wr_addr    = chk_idx_ff;
      wr_data    = {key_ff, rd_count_inc};
      unique case (state_ff)
         TBL_IDLE: begin
            rd_en = scan_en;
            if (cmd.clear) begin
               used_in = '0;
            end
            if (cmd.bump || cmd.find) begin
               state_in = TBL_SCAN;
               bump_in  = cmd.bump;
               key_in   = key;
               idx_in   = '0;
               full_in  = 1'b0;
            end
         end
         TBL_SCAN: begin
            rd_addr = idx_ff[AW-1:0];
            if (hit) begin
               state_in = TBL_IDLE;
               count_in = rd_count;
               if (bump_ff) begin
                  wr_en = 1'b1;
               end
            end else if (miss) begin
               state_in = TBL_IDLE;
               count_in = '0;
               if (bump_ff) begin
                  if (used_ff < UW'(DEPTH)) begin
                     wr_en   = 1'b1;
                     wr_addr = used_ff[AW-1:0];
                     wr_data = {key_ff, COUNT_W'(1)};
                     used_in = used_ff + UW'(1);
                  end else begin
                     full_in = 1'b1;
                  end
               end
            end else if (idx_ff < used_ff) begin
               rd_en      = 1'b1;
               chk_vld_in = 1'b1;
               chk_idx_in = idx_ff[AW-1:0];
               idx_in     = idx_ff + UW'(1);
            end
         end
         default: state_in = TBL_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= TBL_IDLE;
         used_ff    <= '0;
         full_ff    <= 1'b0;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         used_ff    <= used_in;
         full_ff    <= full_in;
         chk_vld_ff <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      bump_ff    <= bump_in;
      key_ff     <= key_in;
      idx_ff     <= idx_in;
      chk_idx_ff <= chk_idx_in;
      count_ff   <= count_in;
   end

   assign sts.busy    = (state_ff == TBL_SCAN);
   assign sts.full    = full_ff;
   assign found_count = count_ff;
   assign scan_key    = rd_key;
   assign scan_count  = rd_count;
   assign used        = used_ff;
endmodule
`default_nettype wire

// ===== src/kse_log2.sv =====
// iterative log2 in q.32: one-bit normalising shift, then one squaring per fraction bit
`default_nettype none
module kse_log2 #(
   parameter int XW = 42,
   parameter int RW = 38
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [XW-1:0] x,
   output logic               busy,
   output logic      [RW-1:0] result
);
   import kse_pkg::*;

   localparam int SW = (XW > FRAC_W) ? XW : FRAC_W;
   localparam int NW = $clog2(SW);

   kse_log_state_type     state_ff, state_in;
   logic [SW-1:0]         s_ff, s_in;
   logic [NW-1:0]         n_ff, n_in;
   logic [FRAC_W-1:0]     m_ff, m_in;
   logic [FRAC_W-1:0]     frac_ff, frac_in;
   logic [4:0]            step_ff, step_in;
   logic [RW-1:0]         result_ff, result_in;
   logic [2*FRAC_W-1:0]   sq;
   logic [FRAC_W:0]       sq_sh;

   assign sq    = (2*FRAC_W)'(m_ff) * (2*FRAC_W)'(m_ff);
   assign sq_sh = sq[2*FRAC_W-1:FRAC_W-1];

   always_comb begin
      state_in  = state_ff;
      s_in      = s_ff;
      n_in      = n_ff;
      m_in      = m_ff;
      frac_in   = frac_ff;
      step_in   = step_ff;
      result_in = result_ff;
      unique case (state_ff)
         LOG_IDLE: begin
            if (start) begin
               if (x == '0) begin
                  result_in = '0;
               end else begin
                  s_in     = SW'(x);
                  n_in     = NW'(SW - 1);
                  state_in = LOG_NORM;
               end
            end
         end
         LOG_NORM: begin
            if (s_ff[SW-1]) begin
               m_in     = s_ff[SW-1 -: FRAC_W];
               frac_in  = '0;
               step_in  = '0;
               state_in = LOG_SQR;
            end else begin
               s_in = {s_ff[SW-2:0], 1'b0};
               n_in = n_ff - NW'(1);
            end
         end
         LOG_SQR: begin
            // a square at or above two gives a one bit and halves the mantissa
            m_in    = sq_sh[FRAC_W] ? sq_sh[FRAC_W:1] : sq_sh[FRAC_W-1:0];
            frac_in = {frac_ff[FRAC_W-2:0], sq_sh[FRAC_W]};
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd31) begin
               result_in = RW'({n_ff, frac_in});
               state_in  = LOG_IDLE;
            end
         end
         default: state_in = LOG_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LOG_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff      <= s_in;
      n_ff      <= n_in;
      m_ff      <= m_in;
      frac_ff   <= frac_in;
      step_ff   <= step_in;
      result_ff <= result_in;
   end

   assign busy   = (state_ff != LOG_IDLE);
   assign result = result_ff;
endmodule
`default_nettype wire

// ===== src/kse_div.sv =====
// restoring divider for the q1.32 probability count / total, one bit a cycle
`default_nettype none
module kse_div #(
   parameter int TW = 42
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [TW-1:0] c,
   input  wire logic [TW-1:0] t,
   output logic               busy,
   output logic [kse_pkg::P_W-1:0] p
);
   import kse_pkg::*;

   kse_div_state_type  state_ff, state_in;
   logic [TW-1:0]      r_ff, r_in;
   logic [TW-1:0]      t_ff, t_in;
   logic [FRAC_W-1:0]  q_ff, q_in;
   logic [4:0]         step_ff, step_in;
   logic [P_W-1:0]     p_ff, p_in;
   logic [TW:0]        r2;
   logic               ge;

   assign r2 = {r_ff, 1'b0};
   assign ge = (r2 >= (TW+1)'(t_ff));

   always_comb begin
      state_in = state_ff;
      r_in     = r_ff;
      t_in     = t_ff;
      q_in     = q_ff;
      step_in  = step_ff;
      p_in     = p_ff;
      unique case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               if (c >= t) begin
                  p_in = {1'b1, {FRAC_W{1'b0}}};
               end else begin
                  r_in     = c;
                  t_in     = t;
                  q_in     = '0;
                  step_in  = '0;
                  state_in = DIV_RUN;
               end
            end
         end
         DIV_RUN: begin
            r_in    = ge ? TW'(r2 - (TW+1)'(t_ff)) : TW'(r2);
            q_in    = {q_ff[FRAC_W-2:0], ge};
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd31) begin
               p_in     = {1'b0, q_in};
               state_in = DIV_IDLE;
            end
         end
         default: state_in = DIV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff    <= r_in;
      t_ff    <= t_in;
      q_ff    <= q_in;
      step_ff <= step_in;
      p_ff    <= p_in;
   end

   assign busy = (state_ff != DIV_IDLE);
   assign p    = p_ff;
endmodule
`default_nettype wire

// ===== src/kmer_shannon_entropy_core.sv =====
// top level: k-mer shannon entropy engine with gram and prefix count tables
`default_nettype none
// Symbols arrive one transaction at a time on req_; the last symbol of a
// sequence produces one transaction on rsp_ carrying entropy, the log2 of the
// distinct gram count and a status, after which the tables are emptied. Each
// table is a single ram searched linearly over its filled entries, so the time
// a symbol takes grows with the grams held, and in conditional mode also with
// the prefixes held. The final pass first sums the counts for the total, then
// per gram runs one log2 (a normalising shift, then one squaring per fraction
// bit) in parallel with a divide, and in conditional mode a prefix search and a
// second log2; outside it a closing log2 of the gram count gives the maximum.
// Configuration registers: index 0 mode, index 1 order; write only while idle.
module kmer_shannon_entropy_core #(
   parameter int TABLE_CAPACITY = 1024,
   parameter int MAX_ORDER      = 4,
   parameter int COUNT_WIDTH    = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write,
   input  wire logic [kse_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [kse_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [kse_pkg::SYMBOL_W-1:0]        req_symbol,
   input  wire logic                                req_last,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic      [kse_pkg::RES_W-1:0]           rsp_entropy_bits,
   output logic      [kse_pkg::RES_W-1:0]           rsp_max_entropy_bits,
   output logic      [$clog2(TABLE_CAPACITY):0]     rsp_distinct_grams,
   output logic      [kse_pkg::STATUS_W-1:0]        rsp_status
);
   import kse_pkg::*;

   localparam int KW      = (MAX_ORDER + 1) * SYMBOL_W;    // gram key
   localparam int PKW     = MAX_ORDER * SYMBOL_W;          // prefix key
   localparam int AW      = $clog2(TABLE_CAPACITY);
   localparam int UW      = AW + 1;
   localparam int TW      = COUNT_WIDTH + AW;              // sum of counts
   localparam int SW      = (TW > FRAC_W) ? TW : FRAC_W;
   localparam int LW      = FRAC_W + $clog2(SW);           // log2 result, q.32
   localparam int DIW     = LW - FRAC_W;
   localparam int HW      = LW + AW + 1;                   // entropy accumulator
   localparam int SEEN_W  = $clog2(MAX_ORDER + 3);
   localparam int CMP_W   = (SEEN_W > G_W) ? SEEN_W : G_W;
   localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(MAX_ORDER + 2);

   function automatic logic [RES_W-1:0] to_out(input logic [HW-1:0] v);
      logic [HW-OUT_SHIFT-1:0] t;
      t = v[HW-1:OUT_SHIFT];
      if (|t[HW-OUT_SHIFT-1:RES_W]) begin
         to_out = '1;
      end else begin
         to_out = t[RES_W-1:0];
      end
   endfunction

   // control state
   kse_state_type         state_ff, state_in;
   logic [MODE_W-1:0]     mode_ff, mode_in;
   logic [ORDER_W-1:0]    order_ff, order_in;
   logic [KW-1:0]         window_ff, window_in;
   logic [SEEN_W-1:0]     seen_ff, seen_in;
   logic                  overflow_ff, overflow_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  chk_vld_ff, chk_vld_in;
   logic [UW-1:0]         idx_ff, idx_in;
   logic [UW-1:0]         j_ff, j_in;

   // datapath
   logic                  last_ff, last_in;
   logic [TW-1:0]         total_ff, total_in;
   logic [LW-1:0]         lt_ff, lt_in;
   logic [LW-1:0]         lc_ff, lc_in;
   logic [LW-1:0]         d_ff, d_in;
   logic [P_W-1:0]        p_ff, p_in;
   logic [KW-1:0]         key_ff, key_in;
   logic [HW-1:0]         h_ff, h_in;
   logic [LW:0]           prod_hi_ff, prod_hi_in;
   logic [P_W+FRAC_W-1:0] prod_lo_ff, prod_lo_in;
   logic [RES_W-1:0]      res_ent_ff, res_ent_in;
   logic [RES_W-1:0]      res_max_ff, res_max_in;
   kse_status_type        res_status_ff, res_status_in;
   logic [RES_W-1:0]      rsp_ent_ff, rsp_ent_in;
   logic [RES_W-1:0]      rsp_max_ff, rsp_max_in;
   logic [UW-1:0]         rsp_dist_ff, rsp_dist_in;
   kse_status_type        rsp_status_ff, rsp_status_in;

   // decode of the registers
   logic [MODE_W-1:0]     m_eff;
   logic [G_W-1:0]        g;
   logic                  counting;
   logic [SEEN_W-1:0]     seen_next;
   logic [KW-1:0]         gkey;
   kse_status_type        status_c;

   // table and unit hookups
   kse_tbl_cmd_type       g_cmd, p_cmd;
   kse_tbl_sts_type       g_sts, p_sts;
   logic                  g_scan_en;
   logic [AW-1:0]         g_scan_addr;
   logic [KW-1:0]         g_scan_key;
   logic [COUNT_WIDTH-1:0] g_scan_count, p_found, g_found_unused;
   logic [UW-1:0]         g_used;
   logic [PKW-1:0]        p_key;
   logic                  log_start, log_busy;
   logic [TW-1:0]         log_x;
   logic [LW-1:0]         log_res;
   logic                  div_start, div_busy;
   logic [P_W-1:0]        div_p;
   logic [HW-1:0]         h_acc, maxq_ext, h_clamp;
   logic [UW-1:0]         j_next;

   assign m_eff     = (mode_ff == MODE_JOINT_ALT) ? MODE_JOINT : mode_ff;
   assign g         = (m_eff == MODE_PLAIN) ? G_W'(1) : G_W'(order_ff) + G_W'(1);
   assign counting  = (m_eff == MODE_PLAIN) ||
                      ((order_ff <= ORDER_W'(MAX_ORDER)) &&
                       !((m_eff == MODE_COND) && (order_ff == '0)));
   assign seen_next = (seen_ff == SEEN_MAX) ? seen_ff : seen_ff + SEEN_W'(1);

   // gram key keeps the newest g symbols of the window
   always_comb begin
      for (int b = 0; b <= MAX_ORDER; b++) begin
         gkey[b*SYMBOL_W +: SYMBOL_W] = (G_W'(b) < g) ? window_ff[b*SYMBOL_W +: SYMBOL_W]
                                                      : '0;
      end
   end

   // status priority: order below one, order too large, then overflow
   always_comb begin
      if ((m_eff == MODE_COND) && (order_ff == '0)) begin
         status_c = STATUS_ORDER_LOW;
      end else if ((m_eff != MODE_PLAIN) &&
                   ((order_ff > ORDER_W'(MAX_ORDER)) ||
                    (CMP_W'(g) >= CMP_W'(seen_ff)))) begin
         status_c = STATUS_ORDER_LARGE;
      end else if (overflow_ff) begin
         status_c = STATUS_OVERFLOW;
      end else begin
         status_c = STATUS_OK;
      end
   end

   kse_table #(.KEY_W(KW), .COUNT_W(COUNT_WIDTH), .DEPTH(TABLE_CAPACITY)) u_gram (
      .clock       (clock),
      .reset       (reset),
      .cmd         (g_cmd),
      .key         (gkey),
      .scan_en     (g_scan_en),
      .scan_addr   (g_scan_addr),
      .sts         (g_sts),
      .found_count (g_found_unused),
      .scan_key    (g_scan_key),
      .scan_count  (g_scan_count),
      .used        (g_used)
   );

   assign p_key = (state_ff == ST_PBUMP) ? gkey[KW-1:SYMBOL_W] : key_ff[KW-1:SYMBOL_W];

   kse_table #(.KEY_W(PKW), .COUNT_W(COUNT_WIDTH), .DEPTH(TABLE_CAPACITY)) u_prefix (
      .clock       (clock),
      .reset       (reset),
      .cmd         (p_cmd),
      .key         (p_key),
      .scan_en     (1'b0),
      .scan_addr   ('0),
      .sts         (p_sts),
      .found_count (p_found),
      .scan_key    (),
      .scan_count  (),
      .used        ()
   );

   kse_log2 #(.XW(TW), .RW(LW)) u_log2 (
      .clock  (clock),
      .reset  (reset),
      .start  (log_start),
      .x      (log_x),
      .busy   (log_busy),
      .result (log_res)
   );

   kse_div #(.TW(TW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .c     (TW'(g_scan_count)),
      .t     (total_ff),
      .busy  (div_busy),
      .p     (div_p)
   );

   assign h_acc    = h_ff + HW'(prod_hi_ff) + HW'(prod_lo_ff[P_W+FRAC_W-1:FRAC_W]);
   assign maxq_ext = HW'(log_res);
   assign h_clamp  = (h_ff > maxq_ext) ? maxq_ext : h_ff;
   assign j_next   = j_ff + UW'(1);

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      order_in      = order_ff;
      window_in     = window_ff;
      seen_in       = seen_ff;
      overflow_in   = overflow_ff;
      rsp_valid_in  = rsp_valid_ff;
      chk_vld_in    = 1'b0;
      idx_in        = idx_ff;
      j_in          = j_ff;
      last_in       = last_ff;
      total_in      = total_ff;
      lt_in         = lt_ff;
      lc_in         = lc_ff;
      d_in          = d_ff;
      p_in          = p_ff;
      key_in        = key_ff;
      h_in          = h_ff;
      prod_hi_in    = prod_hi_ff;
      prod_lo_in    = prod_lo_ff;
      res_ent_in    = res_ent_ff;
      res_max_in    = res_max_ff;
      res_status_in = res_status_ff;
      rsp_ent_in    = rsp_ent_ff;
      rsp_max_in    = rsp_max_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_status_in = rsp_status_ff;
      g_cmd         = '0;
      p_cmd         = '0;
      g_scan_en     = 1'b0;
      g_scan_addr   = j_ff[AW-1:0];
      log_start     = 1'b0;
      log_x         = total_ff;
      div_start     = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write) begin
         if (csr_index == CSR_MODE) begin
            mode_in = csr_wdata[MODE_W-1:0];
         end else if (csr_index == CSR_ORDER) begin
            order_in = csr_wdata[ORDER_W-1:0];
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               window_in = {window_ff[KW-SYMBOL_W-1:0], req_symbol};
               seen_in   = seen_next;
               last_in   = req_last;
               if (counting && (CMP_W'(seen_next) >= CMP_W'(g))) begin
                  state_in = ST_GBUMP;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_GBUMP: begin
            g_cmd.bump = 1'b1;
            state_in   = ST_GWAIT;
         end
         ST_GWAIT: begin
            if (!g_sts.busy) begin
               if (g_sts.full) begin
                  overflow_in = 1'b1;
               end
               state_in = (m_eff == MODE_COND) ? ST_PBUMP : ST_FIN;
            end
         end
         ST_PBUMP: begin
            p_cmd.bump = 1'b1;
            state_in   = ST_PWAIT;
         end
         ST_PWAIT: begin
            if (!p_sts.busy) begin
               if (p_sts.full) begin
                  overflow_in = 1'b1;
               end
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else begin
               res_status_in = status_c;
               res_ent_in    = '0;
               res_max_in    = '0;
               idx_in        = '0;
               j_in          = '0;
               total_in      = '0;
               h_in          = '0;
               if ((status_c != STATUS_OK) || (g_used == '0)) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            // pipelined walk: issue one read, add the previous one
            g_scan_addr = idx_ff[AW-1:0];
            if (chk_vld_ff) begin
               total_in = total_ff + TW'(g_scan_count);
            end
            if (idx_ff < g_used) begin
               g_scan_en  = 1'b1;
               chk_vld_in = 1'b1;
               idx_in     = idx_ff + UW'(1);
            end else if (!chk_vld_ff) begin
               state_in = ST_LT_GO;
            end
         end
         ST_LT_GO: begin
            log_start = 1'b1;
            log_x     = total_ff;
            state_in  = ST_LT_WAIT;
         end
         ST_LT_WAIT: begin
            if (!log_busy) begin
               lt_in    = log_res;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            g_scan_en = 1'b1;
            state_in  = ST_GO;
         end
         ST_GO: begin
            key_in    = g_scan_key;
            log_start = 1'b1;
            log_x     = TW'(g_scan_count);
            div_start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (!log_busy && !div_busy) begin
               lc_in = log_res;
               p_in  = div_p;
               if (m_eff == MODE_COND) begin
                  state_in = ST_PF_GO;
               end else begin
                  d_in     = (lt_ff > log_res) ? lt_ff - log_res : '0;
                  state_in = ST_MUL;
               end
            end
         end
         ST_PF_GO: begin
            p_cmd.find = 1'b1;
            state_in   = ST_PF_WAIT;
         end
         ST_PF_WAIT: begin
            if (!p_sts.busy) begin
               state_in = ST_LP_GO;
            end
         end
         ST_LP_GO: begin
            // an absent prefix reads as zero, whose log2 is zero
            log_start = 1'b1;
            log_x     = TW'(p_found);
            state_in  = ST_LP_WAIT;
         end
         ST_LP_WAIT: begin
            if (!log_busy) begin
               d_in     = (log_res > lc_ff) ? log_res - lc_ff : '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_hi_in = (LW+1)'(p_ff) * (LW+1)'(d_ff[LW-1:FRAC_W]);
            prod_lo_in = (P_W+FRAC_W)'(p_ff) * (P_W+FRAC_W)'(d_ff[FRAC_W-1:0]);
            state_in   = ST_ACC;
         end
         ST_ACC: begin
            h_in = h_acc;
            j_in = j_next;
            if (j_next == g_used) begin
               if (m_eff == MODE_COND) begin
                  res_ent_in = to_out(h_acc);
                  res_max_in = '0;
                  state_in   = ST_EMIT;
               end else begin
                  state_in = ST_MAX_GO;
               end
            end else begin
               state_in = ST_RD;
            end
         end
         ST_MAX_GO: begin
            log_start = 1'b1;
            log_x     = TW'(g_used);
            state_in  = ST_MAX_WAIT;
         end
         ST_MAX_WAIT: begin
            if (!log_busy) begin
               res_ent_in = to_out(h_clamp);
               res_max_in = to_out(maxq_ext);
               state_in   = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // wait for the output register, then empty the tables
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_ent_in    = res_ent_ff;
               rsp_max_in    = res_max_ff;
               rsp_dist_in   = g_used;
               rsp_status_in = res_status_ff;
               g_cmd.clear   = 1'b1;
               p_cmd.clear   = 1'b1;
               window_in     = '0;
               seen_in       = '0;
               overflow_in   = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_RESET;
         order_ff     <= ORDER_RESET;
         window_ff    <= '0;
         seen_ff      <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         chk_vld_ff   <= 1'b0;
         idx_ff       <= '0;
         j_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         order_ff     <= order_in;
         window_ff    <= window_in;
         seen_ff      <= seen_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_vld_ff   <= chk_vld_in;
         idx_ff       <= idx_in;
         j_ff         <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff       <= last_in;
      total_ff      <= total_in;
      lt_ff         <= lt_in;
      lc_ff         <= lc_in;
      d_ff          <= d_in;
      p_ff          <= p_in;
      key_ff        <= key_in;
      h_ff          <= h_in;
      prod_hi_ff    <= prod_hi_in;
      prod_lo_ff    <= prod_lo_in;
      res_ent_ff    <= res_ent_in;
      res_max_ff    <= res_max_in;
      res_status_ff <= res_status_in;
      rsp_ent_ff    <= rsp_ent_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_ready            = (state_ff == ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_entropy_bits     = rsp_ent_ff;
   assign rsp_max_entropy_bits = rsp_max_ff;
   assign rsp_distinct_grams   = rsp_dist_ff;
   assign rsp_status           = rsp_status_ff;
endmodule
`default_nettype wire

// ===== bench/kmer_shannon_entropy_core_tb.sv =====
// self-checking testbench for the k-mer shannon entropy core
`default_nettype none
module kmer_shannon_entropy_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import kse_pkg::*;

   localparam int CAP       = 1024;
   localparam int TOP_ORDER = 4;
   localparam int GRAM_TBL  = 0;
   localparam int PFX_TBL   = 1;
   localparam logic [63:0] COUNT_CEIL = 64'hFFFF_FFFF;
   localparam logic [63:0] ONE_Q32    = 64'd1 << 32;
   localparam int N_PLAN    = 28;

   // one result transaction as the block reports it
   typedef struct packed {
      logic [RES_W-1:0] ent;
      logic [RES_W-1:0] mx;
      logic [10:0]      grams;
      kse_status_type   st;
   } entropy_result_t;

   // one row of the directed stimulus; cfg rows reprogram the core first
   typedef struct {
      bit                cfg;
      logic [MODE_W-1:0]  md;
      logic [ORDER_W-1:0] od;
      logic [7:0]         sym;
      bit                 last;
      bit                 known;
      logic [RES_W-1:0]   e;
      logic [RES_W-1:0]   mx;
      logic [10:0]        dg;
      kse_status_type     st;
   } stim_row_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = CSR_MODE;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [SYMBOL_W-1:0]    req_symbol = '0;
   logic                   req_last = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [RES_W-1:0]       rsp_entropy_bits;
   logic [RES_W-1:0]       rsp_max_entropy_bits;
   logic [10:0]            rsp_distinct_grams;
   logic [STATUS_W-1:0]    rsp_status;

   kmer_shannon_entropy_core dut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_symbol(req_symbol), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_entropy_bits(rsp_entropy_bits),
      .rsp_max_entropy_bits(rsp_max_entropy_bits),
      .rsp_distinct_grams(rsp_distinct_grams), .rsp_status(rsp_status)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // shadow of the core: registers, window and both count tables
   // ---------------------------------------------------------------
   logic [MODE_W-1:0]  cfg_mode;
   logic [ORDER_W-1:0] cfg_order;
   logic [63:0]        win;
   logic [63:0]        seen;
   logic [63:0]        tbl_key [2][CAP];
   logic [63:0]        tbl_cnt [2][CAP];
   int unsigned        tbl_used [2];
   bit                 tbl_ovf;

   entropy_result_t    pending_results[$];
   int unsigned        n_errors = 0;
   int unsigned        n_results = 0;
   int unsigned        n_items = 0;
   int unsigned        status_seen [4];
   int unsigned        idle_req = 38;
   int unsigned        idle_rsp = 78;

   function automatic logic [63:0] byte_window_mask(int unsigned nbytes);
      if (nbytes >= 8) return '1;
      return (64'd1 << (nbytes * 8)) - 64'd1;
   endfunction

   // count one key in a table, flagging overflow when a new key finds it full
   function automatic void tally(int t, logic [63:0] key);
      for (int unsigned i = 0; i < tbl_used[t]; i++) begin
         if (tbl_key[t][i] == key) begin
            if (tbl_cnt[t][i] < COUNT_CEIL) tbl_cnt[t][i]++;
            return;
         end
      end
      if (tbl_used[t] < CAP) begin
         tbl_key[t][tbl_used[t]] = key;
         tbl_cnt[t][tbl_used[t]] = 64'd1;
         tbl_used[t]++;
      end else begin
         tbl_ovf = 1'b1;
      end
   endfunction

   // log2 in q.32: integer part from the msb, fraction by repeated squaring
   function automatic logic [63:0] log2_fix(logic [63:0] x);
      logic [63:0] n;
      logic [63:0] t;
      logic [63:0] m;
      logic [63:0] frac;
      n = 0; t = x; frac = 0;
      if (x == 0) return 0;
      while (t > 1) begin
         t = t >> 1;
         n++;
      end
      m = (n >= 31) ? (x >> (n - 31)) : (x << (31 - n));
      for (int i = 0; i < 32; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= ONE_Q32) begin
            m = m >> 1;
            frac = frac | 64'd1;
         end
      end
      return (n << 32) | frac;
   endfunction

   // probability c/t in q1.32 by restoring division
   function automatic logic [63:0] share_q32(logic [63:0] c, logic [63:0] t);
      logic [63:0] q;
      logic [63:0] r;
      q = 0; r = c;
      if (c >= t) return ONE_Q32;
      for (int i = 0; i < 32; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= t) begin
            r = r - t;
            q = q | 64'd1;
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] weigh(logic [63:0] p, logic [63:0] d);
      return p * (d >> 32) + ((p * (d & 64'hFFFF_FFFF)) >> 32);
   endfunction

   function automatic logic [RES_W-1:0] to_q16(logic [63:0] q32);
      logic [63:0] v;
      v = q32 >> OUT_SHIFT;
      return (v > 64'hFFFFF) ? 20'hFFFFF : v[RES_W-1:0];
   endfunction

   function automatic logic [63:0] prefix_count(logic [63:0] key);
      for (int unsigned i = 0; i < tbl_used[PFX_TBL]; i++)
         if (tbl_key[PFX_TBL][i] == key) return tbl_cnt[PFX_TBL][i];
      return 0;
   endfunction

   function automatic void clear_sequence();
      win = 0;
      seen = 0;
      tbl_used[GRAM_TBL] = 0;
      tbl_used[PFX_TBL] = 0;
      tbl_ovf = 1'b0;
   endfunction

   // advance the shadow by one accepted symbol; returns 1 when a result is due
   function automatic bit entropy_of_symbol(logic [7:0] sym, bit last,
                                            output entropy_result_t r);
      logic [MODE_W-1:0] eff;
      logic [63:0] g;
      bit counting;
      kse_status_type st;
      logic [63:0] total;
      logic [63:0] lt;
      logic [63:0] h;
      logic [63:0] c;
      logic [63:0] lc;
      logic [63:0] lp;
      logic [63:0] d;
      logic [63:0] maxq;
      r = '0;
      eff = (cfg_mode == MODE_JOINT_ALT) ? MODE_JOINT : cfg_mode;
      g = (eff == MODE_PLAIN) ? 64'd1 : 64'(cfg_order) + 64'd1;
      counting = (eff == MODE_PLAIN) ||
                 (cfg_order <= TOP_ORDER && !(eff == MODE_COND && cfg_order == 0));
      win = ((win << 8) | 64'(sym)) & byte_window_mask(TOP_ORDER + 1);
      if (seen < COUNT_CEIL) seen++;
      if (counting && seen >= g) begin
         tally(GRAM_TBL, win & byte_window_mask(g));
         if (eff == MODE_COND) tally(PFX_TBL, (win & byte_window_mask(g)) >> 8);
      end
      if (!last) return 1'b0;

      if (eff == MODE_COND && cfg_order == 0) st = STATUS_ORDER_LOW;
      else if (eff != MODE_PLAIN && (cfg_order > TOP_ORDER || g >= seen))
         st = STATUS_ORDER_LARGE;
      else if (tbl_ovf) st = STATUS_OVERFLOW;
      else st = STATUS_OK;

      if (st == STATUS_OK && tbl_used[GRAM_TBL] > 0) begin
         total = 0;
         h = 0;
         for (int unsigned i = 0; i < tbl_used[GRAM_TBL]; i++)
            total += tbl_cnt[GRAM_TBL][i];
         lt = log2_fix(total);
         for (int unsigned i = 0; i < tbl_used[GRAM_TBL]; i++) begin
            c = tbl_cnt[GRAM_TBL][i];
            lc = log2_fix(c);
            if (eff == MODE_COND) begin
               // an absent or smaller prefix count gives no contribution
               lp = log2_fix(prefix_count(tbl_key[GRAM_TBL][i] >> 8));
               d = (lp > lc) ? lp - lc : 0;
            end else begin
               d = (lt > lc) ? lt - lc : 0;
            end
            h += weigh(share_q32(c, total), d);
         end
         if (eff != MODE_COND) begin
            maxq = log2_fix(64'(tbl_used[GRAM_TBL]));
            if (h > maxq) h = maxq;
            r.mx = to_q16(maxq);
         end
         r.ent = to_q16(h);
      end
      r.grams = tbl_used[GRAM_TBL][10:0];
      r.st = st;
      clear_sequence();
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------
   // mismatch reporting and the response side
   // ---------------------------------------------------------------
   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("[%0t] result %0d: %s got 0x%0h expected 0x%0h",
               $realtime, n_results, what, got, want);
      n_errors++;
   endtask

   always @(posedge clock) begin
      entropy_result_t want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected transaction, status", 32'(rsp_status), 0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_entropy_bits !== want.ent)
                  report_mismatch("entropy_bits", 32'(rsp_entropy_bits), 32'(want.ent));
               if (rsp_max_entropy_bits !== want.mx)
                  report_mismatch("max_entropy_bits", 32'(rsp_max_entropy_bits),
                                  32'(want.mx));
               if (rsp_distinct_grams !== want.grams)
                  report_mismatch("distinct_grams", 32'(rsp_distinct_grams),
                                  32'(want.grams));
               if (rsp_status !== want.st)
                  report_mismatch("status", 32'(rsp_status), 32'(want.st));
               status_seen[want.st]++;
            end
            n_results++;
         end
         rsp_ready <= ($urandom_range(99) >= idle_rsp);
      end
   end

   // ---------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------
   // present one symbol, hold it until the handshake, then update the shadow;
   // a known expectation from the table overrides the predicted one
   task automatic send_symbol(logic [7:0] sym, bit last, bit known = 0,
                              entropy_result_t fixed = '0);
      entropy_result_t r;
      while ($urandom_range(99) < idle_req) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_symbol <= sym;
      req_last   <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      n_items++;
      if (entropy_of_symbol(sym, last, r))
         pending_results.push_back(known ? fixed : r);
   endtask

   // registers change only with the core drained and settled
   task automatic program_core(logic [MODE_W-1:0] md, logic [ORDER_W-1:0] od);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_MODE;
      csr_wdata <= CSR_DATA_W'(md);
      @(posedge clock);
      csr_index <= CSR_ORDER;
      csr_wdata <= od;
      @(posedge clock);
      csr_write <= 1'b0;
      cfg_mode  = md;
      cfg_order = od;
   endtask

   // directed rows: reset values, error codes, extremes, mode three aliasing
   stim_row_t plan [N_PLAN] = '{
      '{1, MODE_JOINT, 0, 8'h00, 1, 1, 0, 0, 1, STATUS_ORDER_LARGE},
      '{0, MODE_JOINT, 0, 8'hFF, 0, 0, 0, 0, 0, STATUS_OK},
      '{0, MODE_JOINT, 0, 8'hFF, 1, 1, 0, 0, 1, STATUS_OK},
      '{1, MODE_COND,  0, 8'h07, 1, 1, 0, 0, 0, STATUS_ORDER_LOW},
      '{1, MODE_PLAIN, 7, 8'h00, 0, 0, 0, 0, 0, STATUS_OK},
      '{0, MODE_PLAIN, 7, 8'h01, 1, 1, 20'h10000, 20'h10000, 2, STATUS_OK},
      '{1, MODE_JOINT, 7, 8'h01, 0, 0, 0, 0, 0, STATUS_OK},
      '{0, MODE_JOINT, 7, 8'h02, 0, 0, 0, 0, 0, STATUS_OK},
      '{0, MODE_JOINT, 7, 8'h03, 1, 1, 0, 0, 0, STATUS_ORDER_LARGE},
      '{1, MODE_JOINT_ALT, 4, 8'hAA, 0, 0, 0, 0, 0, STATUS_OK},
      '{0, MODE_JOINT_ALT, 4, 8'h55, 0, 0, 0, 0, 0, STATUS_OK},
      '{0, MODE_JOINT_ALT, 4, 8'hAA, 0, 0, 0, 0, 0, STATUS_OK},
      '{0, MODE_JOINT_ALT, 4, 8'h55, 0, 0, 0, 0, 0, STATUS_OK},
      '{0, MODE_JOINT_ALT, 4, 8'hAA, 0, 0, 0, 0, 0, STATUS_OK},
      '{0, MODE_JOINT_ALT, 4, 8'h55, 1, 0, 0, 0, 0, STATUS_OK},
      '{1, MODE_COND,  1, 8'h80, 0, 0, 0, 0, 0, STATUS_OK},
      '{0, MODE_COND,  1, 8'h01, 0, 0, 0, 0, 0, STATUS_OK},
      '{0, MODE_COND,  1, 8'h80, 0, 0, 0, 0, 0, STATUS_OK},
      '{0, MODE_COND,  1, 8'h01, 0, 0, 0, 0, 0, STATUS_OK},
      '{0, MODE_COND,  1, 8'h02, 0, 0, 0, 0, 0, STATUS_OK},
      '{0, MODE_COND,  1, 8'h80, 0, 0, 0, 0, 0, STATUS_OK},
      '{0, MODE_COND,  1, 8'h01, 0, 0, 0, 0, 0, STATUS_OK},
      '{0, MODE_COND,  1, 8'hFE, 1, 0, 0, 0, 0, STATUS_OK},
      '{1, MODE_COND,  4, 8'h10, 0, 0, 0, 0, 0, STATUS_OK},
      '{0, MODE_COND,  4, 8'h20, 0, 0, 0, 0, 0, STATUS_OK},
      '{0, MODE_COND,  4, 8'h30, 0, 0, 0, 0, 0, STATUS_OK},
      '{0, MODE_COND,  4, 8'h40, 0, 0, 0, 0, 0, STATUS_OK},
      '{0, MODE_COND,  4, 8'h50, 1, 1, 0, 0, 1, STATUS_ORDER_LARGE}
   };

   initial begin
      entropy_result_t fixed;
      int unsigned len;
      int unsigned base;
      int unsigned n_seq;
      bit narrow;
      cfg_mode  = MODE_RESET;
      cfg_order = ORDER_RESET;
      clear_sequence();
      n_seq = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (plan[i]) begin
         if (plan[i].cfg) program_core(plan[i].md, plan[i].od);
         fixed = '{plan[i].e, plan[i].mx, plan[i].dg, plan[i].st};
         send_symbol(plan[i].sym, plan[i].last, plan[i].known, fixed);
      end

      // random sequences with three idling phases
      while (n_items < 450) begin
         if (n_items < 150) begin
            idle_req = 38; idle_rsp = 78;
         end else if (n_items < 300) begin
            idle_req = 78; idle_rsp = 38;
         end else begin
            idle_req = 0; idle_rsp = 0;
         end
         if ($urandom_range(2) == 0)
            program_core(MODE_W'($urandom_range(3)),
                         ($urandom_range(9) == 0) ? ORDER_W'($urandom_range(7, 5))
                                                  : ORDER_W'($urandom_range(4)));
         len = ($urandom_range(19) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
         // a narrow alphabet makes grams repeat so counts rise above one
         narrow = ($urandom_range(9) < 6);
         base = $urandom_range(252);
         for (int unsigned k = 0; k < len; k++)
            send_symbol(narrow ? 8'(base + $urandom_range(3)) : 8'($urandom_range(255)),
                        k == len - 1);
         n_seq++;
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("covered %0d symbols, %0d results over %0d random sequences",
               n_items, n_results, n_seq);
      $display("status counts ok %0d, order large %0d, order low %0d, overflow %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (n_errors == 0 && pending_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // watchdog covering all stalled phases several times over
   initial begin
      #40ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
`default_nettype wire
